@@ hdl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 1024;
   localparam int BLOCK_W            = 11;   // block numbers and block count
   localparam int BLOCK_MAX          = 2047; // largest count the register holds
   localparam int WORD_W             = 32;   // map bits per memory word
   localparam int BIT_W              = 5;    // bit index within a word
   localparam logic [BLOCK_W-1:0] COUNT_RESET = 11'd1024;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NO_FREE   = 2'd1,
      STAT_BAD_BLOCK = 2'd2
   } status_type;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

endpackage

@@ hdl/bba_map_ram.sv @@
// ----------------------------------------------------------------------------
// bba_map_ram
// Used/free map storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bba_map_ram
   import bba_pkg::*;
#(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = 5
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/bba_word_find.sv @@
// ----------------------------------------------------------------------------
// bba_word_find
// Finds the lowest free bit of one map word; bits past the block count in
// the last word count as used.
// ----------------------------------------------------------------------------
module bba_word_find
   import bba_pkg::*;
(
   input  logic [WORD_W-1:0] word,
   input  logic              is_last,
   input  logic [BIT_W-1:0]  last_bit,
   output logic              found,
   output logic [BIT_W-1:0]  pos
);

   logic [WORD_W-1:0] free_vec;

   always_comb begin
      for (int b = 0; b < WORD_W; b++) begin
         free_vec[b] = !word[b] && !(is_last && (BIT_W'(b) > last_bit));
      end
   end

   // priority encoder, lowest bit wins
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free_vec[b]) begin
            found = 1'b1;
            pos   = BIT_W'(b);
         end
      end
   end

endmodule

@@ hdl/bitmap_block_allocator_top.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top
// First-fit block allocator over a used/free bitmap held in a word memory.
// ----------------------------------------------------------------------------
// Allocate: map words are scanned in order from word 0, one 32-bit word per
//   cycle, until one holds a free block (none free: through the last word);
//   free: read the word, then write it back; a bad number or zero-count
//   allocate goes straight to the reply. One item at a time: a new request
//   is taken only once the reply is loaded (rsp_tready can hold that off).
//   Reset: synchronous; first a clearing pass zeroes one map word per cycle.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top
   import bba_pkg::*;
#(
   parameter int MAX_BLOCKS = MAX_BLOCKS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [10:0] block_number, [15:11] zero
   input  logic [0:0]  req_tuser,   // [0] opcode
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [10:0] granted_block, [15:11] zero
   output logic [1:0]  rsp_tuser,   // [1:0] status
   // configuration: blocks_in_use
   input  logic        csr_wen,
   input  logic [10:0] csr_wdata
);

   // Only the first 2047 blocks can ever be addressed through the 11-bit
   // count, so storage stops there.
   localparam int EFF_MAX = (MAX_BLOCKS < BLOCK_MAX) ? MAX_BLOCKS : BLOCK_MAX;
   localparam int WORDS   = (EFF_MAX + WORD_W - 1) / WORD_W;
   localparam int WAW     = (WORDS > 1) ? $clog2(WORDS) : 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_FREE_RD,
      S_FREE_WR,
      S_RESP
   } state_type;

   state_type         state_ff, state_in;
   logic [BLOCK_W-1:0] csr_ff, csr_in;
   logic [BLOCK_W-1:0] count_ff, count_in;
   logic [WAW-1:0]    idx_ff, idx_in;          // clear / issue / free word
   logic              issue_done_ff, issue_done_in;
   logic              chk_valid_ff, chk_valid_in;
   logic [WAW-1:0]    chk_idx_ff, chk_idx_in;  // word whose data is arriving
   logic [WAW-1:0]    last_word_ff, last_word_in;
   logic [BIT_W-1:0]  last_bit_ff, last_bit_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;          // bit to clear on free
   logic [BLOCK_W-1:0] res_grant_ff, res_grant_in;
   status_type        res_status_ff, res_status_in;
   logic              rsp_tvalid_ff, rsp_tvalid_in;
   logic [BLOCK_W-1:0] rsp_grant_ff, rsp_grant_in;
   status_type        rsp_status_ff, rsp_status_in;

   logic              mem_wen;
   logic [WAW-1:0]    mem_waddr;
   logic [WORD_W-1:0] mem_wdata;
   logic [WAW-1:0]    mem_raddr;
   logic [WORD_W-1:0] mem_rdata;

   logic              find_found;
   logic [BIT_W-1:0]  find_pos;
   logic              chk_is_last;

   logic              req_fire;
   logic              rsp_load;
   logic [BLOCK_W-1:0] req_block;
   logic [BLOCK_W-1:0] cnt_eff;
   logic [BLOCK_W-1:0] cnt_m1;
   logic [BLOCK_W-1:0] blk_m1;

   bba_map_ram #(
      .DEPTH  (WORDS),
      .ADDR_W (WAW)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (mem_wen),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign chk_is_last = (chk_idx_ff == last_word_ff);

   // search unit: lowest free bit of the word just read
   bba_word_find u_word_find (
      .word     (mem_rdata),
      .is_last  (chk_is_last),
      .last_bit (last_bit_ff),
      .found    (find_found),
      .pos      (find_pos)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_block  = req_tdata[BLOCK_W-1:0];

   // count saturated to the storage limit
   assign cnt_eff = (csr_ff > BLOCK_W'(EFF_MAX)) ? BLOCK_W'(EFF_MAX) : csr_ff;
   assign cnt_m1  = cnt_eff - 1'b1;
   assign blk_m1  = req_block - 1'b1;

   assign rsp_load = (state_ff == S_RESP) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      state_in      = state_ff;
      csr_in        = csr_wen ? csr_wdata : csr_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      issue_done_in = issue_done_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = chk_idx_ff;
      last_word_in  = last_word_ff;
      last_bit_in   = last_bit_ff;
      bit_in        = bit_ff;
      res_grant_in  = res_grant_ff;
      res_status_in = res_status_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_grant_in  = rsp_grant_ff;
      rsp_status_in = rsp_status_ff;

      mem_wen   = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = '0;
      mem_raddr = idx_ff;

      case (state_ff)
         S_CLEAR: begin
            // clearing pass: zero one map word per cycle
            mem_wen = 1'b1;
            idx_in  = idx_ff + 1'b1;
            if (idx_ff == WAW'(WORDS - 1)) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               count_in      = cnt_eff;
               idx_in        = '0;
               issue_done_in = 1'b0;
               last_word_in  = cnt_m1[BIT_W +: WAW];
               last_bit_in   = cnt_m1[BIT_W-1:0];
               res_grant_in  = '0;
               res_status_in = STAT_OK;
               if (opcode_type'(req_tuser[0]) == OP_ALLOC) begin
                  if (cnt_eff == '0) begin
                     res_status_in = STAT_NO_FREE;
                     state_in      = S_RESP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  if (req_block == '0 || req_block > cnt_eff) begin
                     res_status_in = STAT_BAD_BLOCK;
                     state_in      = S_RESP;
                  end else begin
                     idx_in   = blk_m1[BIT_W +: WAW];
                     bit_in   = blk_m1[BIT_W-1:0];
                     state_in = S_FREE_RD;
                  end
               end
            end
         end
         S_SCAN: begin
            // issue side: one read per cycle up to the last word
            if (!issue_done_ff) begin
               chk_valid_in  = 1'b1;
               chk_idx_in    = idx_ff;
               idx_in        = idx_ff + 1'b1;
               issue_done_in = (idx_ff == last_word_ff);
            end
            // check side: data of the word read last cycle
            if (chk_valid_ff && find_found) begin
               mem_wen       = 1'b1;
               mem_waddr     = chk_idx_ff;
               mem_wdata     = mem_rdata | (WORD_W'(1) << find_pos);
               res_grant_in  = BLOCK_W'({chk_idx_ff, find_pos}) + 1'b1;
               res_status_in = STAT_OK;
               chk_valid_in  = 1'b0;
               state_in      = S_RESP;
            end else if (chk_valid_ff && chk_is_last) begin
               res_status_in = STAT_NO_FREE;
               chk_valid_in  = 1'b0;
               state_in      = S_RESP;
            end
         end
         S_FREE_RD: begin
            state_in = S_FREE_WR;
         end
         S_FREE_WR: begin
            mem_wen   = 1'b1;
            mem_wdata = mem_rdata & ~(WORD_W'(1) << bit_ff);
            state_in  = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               rsp_tvalid_in = 1'b1;
               rsp_grant_in  = res_grant_ff;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         csr_ff        <= COUNT_RESET;
         idx_ff        <= '0;
         issue_done_ff <= 1'b0;
         chk_valid_ff  <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         csr_ff        <= csr_in;
         idx_ff        <= idx_in;
         issue_done_ff <= issue_done_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      count_ff      <= count_in;
      chk_idx_ff    <= chk_idx_in;
      last_word_ff  <= last_word_in;
      last_bit_ff   <= last_bit_in;
      bit_ff        <= bit_in;
      res_grant_ff  <= res_grant_in;
      res_status_ff <= res_status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(16 - BLOCK_W){1'b0}}, rsp_grant_ff};
   assign rsp_tuser  = rsp_status_ff;

   // a map write during a scan only happens on a found free bit
   a_scan_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && mem_wen) |-> (chk_valid_ff && find_found))
      else $error("map write during scan without a free bit");

   // a granted block lies inside the block count
   a_grant_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && chk_valid_ff && find_found)
         |-> (res_grant_in != '0 && res_grant_in <= count_ff))
      else $error("granted block outside the block count");

   // nonzero grant is only ever reported with ok status
   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_grant_ff != '0) |-> (rsp_status_ff == STAT_OK))
      else $error("nonzero grant with error status");

   // no request ready as reset is released and the clearing pass starts
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      $fell(reset) |-> !req_tready)
      else $error("request ready before the map is cleared");

endmodule

@@ test/bitmap_block_allocator_top_tb.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator_top_tb
// Self-checking bench for the first-fit block allocator. A local copy of the
// used/free map and of the block count predicts each reply, and replies are
// checked in order. The bench covers directed corner cases, a long random
// mix, a pass that fills the whole map, and random runs at a range of counts.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_top_tb
   import bba_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 4000; // cycles with no handshake on either side
   localparam int SETTLE_CYCLES  = 40;   // full 32-word scan plus pipeline
   localparam int IDLE_PCT       = 27;

   typedef struct packed {
      logic [BLOCK_W-1:0] granted;
      status_type         status;
   } alloc_reply_type;

   // DUT ports; every input is known from time zero
   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [15:0]        req_tdata  = '0;    // [10:0] block_number, [15:11] zero
   logic [0:0]         req_tuser  = OP_ALLOC; // [0] opcode
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [15:0]        rsp_tdata;          // [10:0] granted_block, [15:11] zero
   logic [1:0]         rsp_tuser;          // [1:0] status
   logic               csr_wen    = 1'b0;
   logic [BLOCK_W-1:0] csr_wdata  = '0;

   // predictor state: one bit per block, plus the programmed block count
   bit [MAX_BLOCKS_DEFAULT-1:0] block_used = '0;
   logic [BLOCK_W-1:0]          block_count = COUNT_RESET;
   bit                          map_full_seen = 1'b0;

   alloc_reply_type expected_replies[$];
   int              mismatches = 0;
   int              quiet_cycles = 0;
   bit              no_idle = 1'b0;   // both sides stream without gaps while set

   always #5 clock = ~clock;

   bitmap_block_allocator_top #(
      .MAX_BLOCKS(MAX_BLOCKS_DEFAULT)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // counts above the map size saturate to the map size
   function automatic int managed_blocks();
      return (block_count > MAX_BLOCKS_DEFAULT) ? MAX_BLOCKS_DEFAULT : int'(block_count);
   endfunction

   // first fit on allocate, clear on free; updates the local map
   function automatic alloc_reply_type predict_reply(opcode_type op,
                                                      logic [BLOCK_W-1:0] num);
      alloc_reply_type reply;
      int              lim;
      bit              found;
      lim           = managed_blocks();
      found         = 1'b0;
      reply.granted = '0;
      reply.status  = STAT_OK;
      if (op == OP_ALLOC) begin
         for (int i = 0; i < lim; i++) begin
            if (!found && !block_used[i]) begin
               block_used[i] = 1'b1;
               reply.granted = BLOCK_W'(i + 1);
               found         = 1'b1;
            end
         end
         if (!found) begin
            reply.status  = STAT_NO_FREE;
            map_full_seen = 1'b1;
         end
      end else if (num == 0 || num > lim) begin
         reply.status = STAT_BAD_BLOCK;
      end else begin
         block_used[num-1] = 1'b0;
      end
      return reply;
   endfunction

   // ---------------------------------------------------------------------
   // Reply checker and receiver stalls
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      alloc_reply_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected reply: expected none, actual granted_block %0d status %0d",
                     $time, rsp_tdata[BLOCK_W-1:0], rsp_tuser);
            mismatches++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_tdata[BLOCK_W-1:0] !== want.granted) begin
               $display("%0t: granted_block mismatch: expected %0d, actual %0d",
                        $time, want.granted, rsp_tdata[BLOCK_W-1:0]);
               mismatches++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, want.status, rsp_tuser);
               mismatches++;
            end
         end
      end
      rsp_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   // watchdog: any handshake on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("bitmap_block_allocator_top regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Shared stimulus tasks
   // ---------------------------------------------------------------------

   // Sends one item. Valid stays high between back-to-back items and is
   // only lowered for a gap, so it never drops and rises in one step.
   task automatic send_item(opcode_type op, logic [BLOCK_W-1:0] num);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {5'b0, num};
      do @(posedge clock); while (!req_tready);
      expected_replies.push_back(predict_reply(op, num));
   endtask

   // stop sending and wait until every predicted reply has come back
   task automatic drain_replies();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
   endtask

   // the count register is only written with the block idle
   task automatic write_block_count(logic [BLOCK_W-1:0] value);
      drain_replies();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen     <= 1'b0;
      block_count  = value;
   endtask

   // free targets: mostly inside the managed range, some zero or beyond it
   function automatic logic [BLOCK_W-1:0] pick_free_target();
      int lim;
      int sel;
      lim = managed_blocks();
      sel = $urandom_range(99);
      if (lim > 0 && sel < 75) return BLOCK_W'($urandom_range(lim, 1));
      if (sel < 85) return '0;
      if (sel < 95 && lim < BLOCK_MAX) return BLOCK_W'($urandom_range(BLOCK_MAX, lim + 1));
      return BLOCK_W'($urandom_range(BLOCK_MAX, 0));
   endfunction

   task automatic run_random(int n_items, int alloc_pct);
      for (int k = 0; k < n_items; k++) begin
         // now and then hold off until the block has answered everything
         if ($urandom_range(199) == 0) drain_replies();
         if ($urandom_range(99) < alloc_pct) begin
            send_item(OP_ALLOC, BLOCK_W'($urandom_range(BLOCK_MAX, 0)));
         end else begin
            send_item(OP_FREE, pick_free_target());
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reset count: first fit, reuse of a freed block, bad and already-free numbers
   task automatic test_alloc_free_basics();
      send_item(OP_ALLOC, 11'd2047);   // block number ignored on allocate
      send_item(OP_ALLOC, 11'd0);
      send_item(OP_ALLOC, 11'd0);
      send_item(OP_FREE,  11'd2);
      send_item(OP_ALLOC, 11'd5);      // lowest free is block 2 again
      send_item(OP_FREE,  11'd0);      // block 0 is never valid
      send_item(OP_FREE,  11'd1024);   // top block, already free
      send_item(OP_FREE,  11'd1025);   // just past the count
      send_item(OP_FREE,  11'd2047);
   endtask

   // count of one, zero, and a count above the map size
   task automatic test_count_extremes();
      write_block_count(11'd1);
      send_item(OP_ALLOC, 11'd0);      // block 1 in use: no free block
      send_item(OP_FREE,  11'd2);
      send_item(OP_FREE,  11'd1);
      send_item(OP_ALLOC, 11'd0);
      write_block_count(11'd0);
      send_item(OP_ALLOC, 11'd0);
      send_item(OP_FREE,  11'd1);
      write_block_count(11'd2047);     // saturates to the map size
      send_item(OP_FREE,  11'd1024);
      send_item(OP_FREE,  11'd1025);
   endtask

   // lowering the count hides used blocks above it until raised again
   task automatic test_count_lowered();
      write_block_count(11'd5);
      send_item(OP_ALLOC, 11'd0);
      send_item(OP_ALLOC, 11'd0);
      send_item(OP_ALLOC, 11'd0);
      send_item(OP_ALLOC, 11'd0);      // all five used
      write_block_count(11'd3);
      send_item(OP_ALLOC, 11'd0);
      send_item(OP_FREE,  11'd4);      // above the lowered count
      write_block_count(11'd5);
      send_item(OP_FREE,  11'd4);
      send_item(OP_ALLOC, 11'd0);
   endtask

   // long allocate-heavy mix at full count, with a stretch of no idling
   task automatic test_random_mix();
      write_block_count(11'd1024);
      run_random(200, 88);
      no_idle <= 1'b1;
      run_random(120, 88);
      no_idle <= 1'b0;
      run_random(180, 88);
   endtask

   // push the scan out to the last map word and into the no-free case
   task automatic test_fill_map();
      write_block_count(11'd2047);
      map_full_seen = 1'b0;
      for (int k = 0; k < 1500 && !map_full_seen; k++) begin
         if ($urandom_range(99) < 97) send_item(OP_ALLOC, BLOCK_W'($urandom_range(BLOCK_MAX, 0)));
         else send_item(OP_FREE, pick_free_target());
      end
      run_random(20, 60);
   endtask

   task automatic test_random_small_counts();
      write_block_count(11'd40);
      run_random(15, 50);
      write_block_count(11'd33);       // one bit into the second word
      run_random(15, 50);
      write_block_count(11'd1);
      run_random(15, 50);
      write_block_count(11'd0);
      run_random(15, 50);
      write_block_count(11'd32);
      run_random(15, 50);
      write_block_count(11'd1023);
      run_random(15, 50);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_alloc_free_basics();
      test_count_extremes();
      test_count_lowered();
      test_random_mix();
      test_fill_map();
      test_random_small_counts();

      drain_replies();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("bitmap_block_allocator_top regression: pass");
      end else begin
         $display("bitmap_block_allocator_top regression: fail");
      end
      $finish;
   end

endmodule
